// File: hw/rtl/latency_statistics_monitor_top_defines.svh
// Assertion helpers, sampled on clk, disabled during rst.
`ifndef LATENCY_STATISTICS_MONITOR_TOP_DEFINES_SVH
`define LATENCY_STATISTICS_MONITOR_TOP_DEFINES_SVH

// same-cycle implication
`define LSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lsm_pkg.sv
`timescale 1ns / 1ps

package lsm_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned SumW      = 64;
  localparam int unsigned CpuW      = 10;
  localparam int unsigned DeadW     = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned ProdW     = CpuW + DeadW + 1;

  localparam logic [CpuW-1:0]  CpuReset      = CpuW'(240);
  localparam logic [DeadW-1:0] DeadlineReset = DeadW'(100);
  localparam logic [TimeW-1:0] Max32         = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CYCLES_PER_US = 2'd0,
    REG_DEADLINE_US   = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CHECK,
    ST_DIVIDE,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] event_time;
    logic [TimeW-1:0] service_time;
    logic             clear_stats;
  } in_word_t;

  typedef struct packed {
    logic [TimeW-1:0] sample_count;
    logic [TimeW-1:0] latency_last;
    logic [TimeW-1:0] latency_mean;
    logic [TimeW-1:0] latency_max;
    logic [TimeW-1:0] latency_min;
    logic [TimeW-1:0] miss_count;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/lsm_div.sv
`timescale 1ns / 1ps
`include "latency_statistics_monitor_top_defines.svh"

// Restoring radix-2 divider, one quotient bit per cycle, low 32 quotient bits kept.
module lsm_div
  import lsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SumW-1:0]  dividend,
  input  logic [TimeW-1:0] divisor,
  output div_stat_t        stat,
  output logic [TimeW-1:0] quotient
);

  localparam int unsigned Steps = SumW;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic             busy;
  logic             done;
  logic [CntW-1:0]  cnt;
  logic [SumW-1:0]  dvd;
  logic [TimeW-1:0] dsr;
  logic [TimeW-1:0] rem;
  logic [TimeW-1:0] quo;

  logic [TimeW:0]   trial;
  logic [TimeW:0]   diff;
  logic             ge;

  assign trial = {rem, dvd[SumW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CntW'(Steps);
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[SumW-2:0], 1'b0};
      rem <= ge ? diff[TimeW-1:0] : trial[TimeW-1:0];
      quo <= {quo[TimeW-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

  `LSM_ASSERT_NXT(a_start_busy, start && !busy, busy, "divider did not start")
  `LSM_ASSERT_NOW(a_done_idle, done, !busy, "divider done while busy")
  `LSM_ASSERT_NOW(a_fell_done, $fell(busy), done, "divider stopped without done")

endmodule

// File: hw/rtl/latency_statistics_monitor_top.sv
// Order of work per word: input accept, update, deadline check, 64-step radix-2
//   mean division, output load; the output load waits while out_stall holds a result.
// A new word is accepted only in idle, after the last one has left the bit-serial divider;
//   the next word is accepted while a result still waits in the output register.
// Reset: statistics cleared (min all ones), cycles_per_us = 240, deadline_us = 100,
//   no result pending.
`timescale 1ns / 1ps
`include "latency_statistics_monitor_top_defines.svh"

module latency_statistics_monitor_top
  import lsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_word,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  state_t state;
  state_t state_next;

  logic [CpuW-1:0]  cpu_reg;
  logic [DeadW-1:0] deadline_reg;

  logic [TimeW-1:0] lat_reg;
  logic             clr_reg;
  logic [TimeW-1:0] count_reg;
  logic [SumW-1:0]  sum_reg;
  logic [TimeW-1:0] mean_reg;
  logic [TimeW-1:0] max_reg;
  logic [TimeW-1:0] min_reg;
  logic [TimeW-1:0] miss_reg;
  logic [ProdW-1:0] limit_reg;

  logic             in_acc;
  logic             out_free;
  logic             div_start;
  div_stat_t        div_stat;
  logic [TimeW-1:0] div_quo;

  logic [TimeW-1:0] count_base;
  logic [SumW-1:0]  sum_base;
  logic [TimeW-1:0] max_base;
  logic [TimeW-1:0] min_base;
  logic [SumW:0]    sum_add;
  logic [CpuW-1:0]  cpu_eff;
  logic [DeadW:0]   dead_p1;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_CHECK;
      ST_CHECK:  state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_stat.done) state_next = ST_WRITE;
      ST_WRITE:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_CHECK: div_start = 1'b1;
      default: begin
        in_stall  = 1'b1;
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_reg      <= CpuReset;
      deadline_reg <= DeadlineReset;
    end else if (cfg_write) begin
      if (cfg_index == REG_CYCLES_PER_US) begin
        cpu_reg <= cfg_data[CpuW-1:0];
      end else if (cfg_index == REG_DEADLINE_US) begin
        deadline_reg <= cfg_data[DeadW-1:0];
      end
    end
  end

  // clear applies before the sample is accounted
  assign count_base = clr_reg ? '0 : count_reg;
  assign sum_base   = clr_reg ? '0 : sum_reg;
  assign max_base   = clr_reg ? '0 : max_reg;
  assign min_base   = clr_reg ? Max32 : min_reg;
  assign sum_add    = {1'b0, sum_base} + {{(SumW - TimeW + 1){1'b0}}, lat_reg};
  assign cpu_eff    = (cpu_reg == '0) ? CpuW'(1) : cpu_reg;
  assign dead_p1    = {1'b0, deadline_reg} + (DeadW + 1)'(1);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lat_reg <= in_word.service_time - in_word.event_time;
      clr_reg <= in_word.clear_stats;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= '0;
      sum_reg   <= '0;
      mean_reg  <= '0;
      max_reg   <= '0;
      min_reg   <= Max32;
      miss_reg  <= '0;
    end else begin
      unique case (state)
        ST_UPDATE: begin
          count_reg <= (count_base == Max32) ? Max32 : count_base + TimeW'(1);
          sum_reg   <= sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
          max_reg   <= (lat_reg > max_base) ? lat_reg : max_base;
          min_reg   <= (lat_reg < min_base) ? lat_reg : min_base;
          if (clr_reg) begin
            miss_reg <= '0;
          end
        end
        // floor(lat / d) > deadline  <=>  lat >= (deadline + 1) * d
        ST_CHECK: begin
          if (lat_reg >= {{(TimeW - ProdW){1'b0}}, limit_reg}) begin
            miss_reg <= miss_reg + TimeW'(1);
          end
        end
        ST_DIVIDE: begin
          if (div_stat.done) begin
            mean_reg <= div_quo;
          end
        end
        default: begin
          mean_reg <= mean_reg;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      limit_reg <= dead_p1 * cpu_eff;
    end
  end

  lsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_reg),
    .divisor  (count_reg),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WRITE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && out_free) begin
      out_word.sample_count <= count_reg;
      out_word.latency_last <= lat_reg;
      out_word.latency_mean <= mean_reg;
      out_word.latency_max  <= max_reg;
      out_word.latency_min  <= min_reg;
      out_word.miss_count   <= miss_reg;
    end
  end

  `LSM_ASSERT_NXT(a_acc_update, in_acc, state == ST_UPDATE, "accept did not start update")
  `LSM_ASSERT_NOW(a_done_divide, div_stat.done, state == ST_DIVIDE, "divider done outside divide")
  `LSM_ASSERT_NXT(a_write_load, state == ST_WRITE && out_free, out_valid, "result not loaded")
  `LSM_ASSERT_NOW(a_min_max, $rose(out_valid),
    out_word.latency_min <= out_word.latency_max && out_word.sample_count != '0,
    "result statistics inconsistent")

endmodule
